// File: hdl/otf_pkg.sv
// ============================================================================
// otf_pkg
// Shared types and constants for the overwriting trace FIFO.
// ============================================================================
package otf_pkg;

  // Fixed field widths of the channels
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FillW  = 10;
  localparam int unsigned CountW = 8;

  // Saturation point of the per-request real-byte count
  localparam logic [CountW-1:0] CountMax = '1;

  // Item command codes
  typedef enum logic [0:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_t;

  // Result fields carried from the access stage to the output stage
  typedef struct packed {
    logic              real_byte;
    logic [CountW-1:0] bytes_sent;
    logic [FillW-1:0]  fill_level;
  } rd_info_t;

endpackage

// File: hdl/overwriting_trace_fifo_unit.sv
// ============================================================================
// overwriting_trace_fifo_unit
// Byte ring FIFO for trace data that overwrites its oldest byte when full.
// ============================================================================
// Usage:
//   The input channel (in_valid / in_stall) carries one item per accepted
//   edge: in_cmd selects a write of in_data_byte or a read of one byte;
//   in_first_in_request on a read restarts the per-request real-byte count.
//   Writes are not refused when full and give no result. Each read gives one
//   result on the output channel (out_valid / out_stall): the oldest byte
//   with out_real_byte set, or a zero pad when the FIFO is empty, plus the
//   running count of real bytes in the request and the fill level after it.
//   A read result shows at out_valid once the output register loads it; the
//   accept edge does the synchronous byte-store read and fills the access
//   stage, and the output register loads when the access stage moves on.
//   Throughput: one item per cycle while in_stall is low; the byte store has one
//   write and one read port, and pointers and counts update at the accept edge.
//   Reset clears the pointers, the fill count and the request count and
//   empties both pipeline stages; the byte store is not cleared.
//   When the receiver stalls, the output register holds its result, the
//   access stage holds the next read, and in_stall rises once both are full.
// ============================================================================
module overwriting_trace_fifo_unit #(
  parameter int unsigned DEPTH = 512
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [otf_pkg::ByteW-1:0]        in_data_byte,
  input  logic                             in_first_in_request,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [otf_pkg::ByteW-1:0]        out_byte,
  output logic                             out_real_byte,
  output logic [otf_pkg::CountW-1:0]       out_bytes_sent,
  output logic [otf_pkg::FillW-1:0]        out_fill_level
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  // Byte store and its registered read data
  logic [otf_pkg::ByteW-1:0] mem [DEPTH];
  logic [otf_pkg::ByteW-1:0] rd_q;

  // Pointer and count state
  logic [AW-1:0]             wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]             rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]             held_r, held_nxt;
  logic [otf_pkg::CountW-1:0] cnt_r, cnt_nxt;

  // Access stage and output stage
  logic                      p1_v_r;
  otf_pkg::rd_info_t         p1_info_r, p1_info_nxt;
  logic                      out_v_r;
  otf_pkg::rd_info_t         out_info_r;
  logic [otf_pkg::ByteW-1:0] out_byte_r;

  logic                      p1_adv;
  logic                      in_acc;
  logic                      wr_en;
  logic                      rd_en;
  logic [otf_pkg::CountW-1:0] cnt_base;

  // Move the access stage on when the output register is free or emptying
  assign p1_adv   = p1_v_r && (!out_v_r || !out_stall);
  assign in_stall = p1_v_r && !p1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && (otf_pkg::cmd_t'(in_cmd) == otf_pkg::CMD_WRITE);
  assign rd_en    = in_acc && (otf_pkg::cmd_t'(in_cmd) == otf_pkg::CMD_READ);

  // Update pointers, fill count and request count for the accepted item
  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    held_nxt    = held_r;
    cnt_nxt     = cnt_r;
    cnt_base    = in_first_in_request ? '0 : cnt_r;
    p1_info_nxt = p1_info_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LastIdx) ? '0 : wr_ptr_r + 1'b1;
      if (held_r < FullCnt) begin
        held_nxt = held_r + 1'b1;
      end else begin
        rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
      end
    end else if (rd_en) begin
      cnt_nxt = cnt_base;
      if (held_r != '0) begin
        rd_ptr_nxt = (rd_ptr_r == LastIdx) ? '0 : rd_ptr_r + 1'b1;
        held_nxt   = held_r - 1'b1;
        if (cnt_base != otf_pkg::CountMax) begin
          cnt_nxt = cnt_base + 1'b1;
        end
      end
      p1_info_nxt.real_byte  = (held_r != '0);
      p1_info_nxt.bytes_sent = cnt_nxt;
      p1_info_nxt.fill_level = otf_pkg::FillW'(held_nxt);
    end
  end

  // Write and read the byte store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= in_data_byte;
    end
    if (rd_en) begin
      rd_q <= mem[rd_ptr_r];
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      held_r   <= '0;
      cnt_r    <= '0;
      p1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      held_r   <= held_nxt;
      cnt_r    <= cnt_nxt;
      if (rd_en) begin
        p1_v_r <= 1'b1;
      end else if (p1_adv) begin
        p1_v_r <= 1'b0;
      end
      if (p1_adv) begin
        out_v_r <= 1'b1;
      end else if (!out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Advance payload through the stages
  always_ff @(posedge clk) begin
    if (rd_en) begin
      p1_info_r <= p1_info_nxt;
    end
    if (p1_adv) begin
      out_info_r <= p1_info_r;
      out_byte_r <= p1_info_r.real_byte ? rd_q : '0;
    end
  end

  assign out_valid      = out_v_r;
  assign out_byte       = out_byte_r;
  assign out_real_byte  = out_info_r.real_byte;
  assign out_bytes_sent = out_info_r.bytes_sent;
  assign out_fill_level = out_info_r.fill_level;

  // Fill count never exceeds the store depth
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= FullCnt)
    else $error("held count above depth");

  // A padding result reports an empty FIFO
  a_pad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_info_r.real_byte |-> out_info_r.fill_level == '0)
    else $error("padding result with nonzero fill level");

  // A real byte always counts in its request
  a_real_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_info_r.real_byte |-> out_info_r.bytes_sent != '0)
    else $error("real byte with zero request count");

  // A blocked access stage keeps its read
  a_p1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r && !p1_adv |=> p1_v_r && $stable(p1_info_r))
    else $error("access stage lost a held read");

endmodule
